// ----- src/keyframe_cut_point_finder_core_defines.svh -----
// Assertion macros used by the checker file of the cut point finder.
`ifndef KEYFRAME_CUT_POINT_FINDER_CORE_DEFINES_SVH
`define KEYFRAME_CUT_POINT_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define KCPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define KCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/kcpf_pkg.sv -----
// Package of the cut point finder: widths, register indexes and the candidate type.
`default_nettype none

package kcpf_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int IDX_W      = 16;
  localparam int POS_W      = 31;
  localparam int TIME_W     = 31;
  localparam int DUR_W      = 24;
  localparam int THR_W      = 24;
  localparam int CFG_IDX_W  = 2;

  // The frame index stops at the smaller of the list size and the index range.
  localparam int CNT_LIMIT = (MAX_FRAMES - 1 > (1 << IDX_W) - 1) ?
                             (1 << IDX_W) - 1 : MAX_FRAMES - 1;

  localparam logic [THR_W-1:0] CLIP_THRESHOLD_RST = THR_W'(6000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUT_TIME       = 2'd0,
    REG_VIDEO_ONLY     = 2'd1,
    REG_CLIP_THRESHOLD = 2'd2
  } kcpf_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] offset;
  } kcpf_cand_t;

endpackage

`default_nettype wire

// ----- src/kcpf_resolve.sv -----
// Final pairing of the left and right keyframe candidates at the end of a list.
`default_nettype none

module kcpf_resolve (
  input  wire logic                      left_valid,
  input  wire logic                      right_valid,
  input  wire kcpf_pkg::kcpf_cand_t      left_cand,
  input  wire kcpf_pkg::kcpf_cand_t      right_cand,
  input  wire logic [kcpf_pkg::TIME_W-1:0] cut_time,
  input  wire logic [kcpf_pkg::THR_W-1:0]  clip_threshold,
  output logic                           found,
  output kcpf_pkg::kcpf_cand_t           left_sel,
  output kcpf_pkg::kcpf_cand_t           right_sel
);

  logic                          before_cut;
  logic [kcpf_pkg::TIME_W-1:0]   past_cut;
  logic                          near_cut;

  always_comb begin
    right_sel  = right_valid ? right_cand : left_cand;
    before_cut = right_sel.offset < cut_time;
    past_cut   = right_sel.offset - cut_time;
    near_cut   = past_cut < {{(kcpf_pkg::TIME_W - kcpf_pkg::THR_W){1'b0}}, clip_threshold};
    // Right serves as both ends if no left, or if before or near past the cut.
    left_sel   = (!left_valid || before_cut || near_cut) ? right_sel : left_cand;
    found      = left_valid | right_valid;
  end

endmodule

`default_nettype wire

// ----- src/keyframe_cut_point_finder_core.sv -----
// Top level of the keyframe cut point finder.
//
// Frame descriptors enter on the in_ channel, one word per cycle, and are accepted
// when in_valid is high and in_stall is low. Each word takes the next frame index
// and updates the running time offset and the left and right keyframe candidates.
// The word flagged by in_last closes the list: the pair is resolved and one result
// word appears on the out_ channel in the next cycle, held until out_stall is low.
// The scan state then returns to zero for the next list; configuration is kept.
// Throughput is one descriptor per cycle while in_stall is low, set by the update of
// the time accumulator and candidate registers; the result register lies between
// the last word and the result.
// in_stall is raised only while a result is waiting and out_stall holds it, so
// descriptors keep flowing while the receiver takes the previous result.
// Configuration writes (cfg_valid, always ready) must come only while idle; the block itself does not enforce this.
// rst_n is synchronous: it clears the scan state and out_valid, and sets
// the cut time to 0, video_only to 0 and clip_threshold to 6000.
`default_nettype none

module keyframe_cut_point_finder_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kcpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kcpf_pkg::TIME_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_is_video_frame,
  input  wire logic                           in_is_keyframe,
  input  wire logic                           in_has_clock_ref,
  input  wire logic [kcpf_pkg::DUR_W-1:0]     in_duration,
  input  wire logic [kcpf_pkg::POS_W-1:0]     in_position,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_found,
  output logic [kcpf_pkg::IDX_W-1:0]          out_left_index,
  output logic [kcpf_pkg::POS_W-1:0]          out_left_pos,
  output logic [kcpf_pkg::TIME_W-1:0]         out_left_offset,
  output logic [kcpf_pkg::IDX_W-1:0]          out_right_index,
  output logic [kcpf_pkg::POS_W-1:0]          out_right_pos,
  output logic [kcpf_pkg::TIME_W-1:0]         out_right_offset
);

  // Configuration
  logic [kcpf_pkg::TIME_W-1:0] cut_time_r;
  logic                        video_only_r;
  logic [kcpf_pkg::THR_W-1:0]  clip_threshold_r;

  // Scan state
  logic [kcpf_pkg::TIME_W-1:0] time_acc_r, time_acc_nxt;
  logic [kcpf_pkg::IDX_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic                        search_done_r, search_done_nxt;
  logic                        left_valid_r, left_valid_nxt;
  logic                        right_valid_r, right_valid_nxt;
  kcpf_pkg::kcpf_cand_t        left_r, left_nxt;
  kcpf_pkg::kcpf_cand_t        right_r, right_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r;
  kcpf_pkg::kcpf_cand_t        out_left_r, out_right_r;

  logic                        in_fire;
  logic                        counted;
  logic [kcpf_pkg::TIME_W:0]   time_sum;
  logic [kcpf_pkg::TIME_W-1:0] time_sat;
  logic [kcpf_pkg::TIME_W-1:0] to_cut;
  logic                        res_found;
  kcpf_pkg::kcpf_cand_t        res_left, res_right;
  kcpf_pkg::kcpf_cand_t        this_frame;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_time_r       <= '0;
      video_only_r     <= 1'b0;
      clip_threshold_r <= kcpf_pkg::CLIP_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kcpf_pkg::REG_CUT_TIME:       cut_time_r       <= cfg_data;
        kcpf_pkg::REG_VIDEO_ONLY:     video_only_r     <= cfg_data[0];
        kcpf_pkg::REG_CLIP_THRESHOLD: clip_threshold_r <= cfg_data[kcpf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    counted  = ~search_done_r & ~(video_only_r & ~in_is_video_frame);
    time_sum = {1'b0, time_acc_r} +
               {{(kcpf_pkg::TIME_W + 1 - kcpf_pkg::DUR_W){1'b0}}, in_duration};
    time_sat = time_sum[kcpf_pkg::TIME_W] ? '1 : time_sum[kcpf_pkg::TIME_W-1:0];
    to_cut   = cut_time_r - time_acc_r;

    this_frame.index  = frame_cnt_r;
    this_frame.pos    = in_position;
    this_frame.offset = time_acc_r;

    frame_cnt_nxt   = (frame_cnt_r < kcpf_pkg::IDX_W'(kcpf_pkg::CNT_LIMIT)) ?
                      frame_cnt_r + 1'b1 : frame_cnt_r;
    time_acc_nxt    = time_acc_r;
    search_done_nxt = search_done_r;
    left_valid_nxt  = left_valid_r;
    right_valid_nxt = right_valid_r;
    left_nxt        = left_r;
    right_nxt       = right_r;

    if (counted) begin
      if (!(in_is_keyframe && in_has_clock_ref)) begin
        time_acc_nxt = time_sat;
      end else if (time_acc_r >= cut_time_r) begin
        right_valid_nxt = 1'b1;
        right_nxt       = this_frame;
        search_done_nxt = 1'b1;
      end else begin
        left_valid_nxt = 1'b1;
        left_nxt       = this_frame;
        // A left keyframe close enough to the cut ends the search.
        if (to_cut < {{(kcpf_pkg::TIME_W - kcpf_pkg::THR_W){1'b0}}, clip_threshold_r}) begin
          search_done_nxt = 1'b1;
        end else begin
          time_acc_nxt = time_sat;
        end
      end
    end

    out_valid_nxt = (in_fire & in_last) | (out_valid_r & out_stall);
  end

  kcpf_resolve u_resolve (
    .left_valid     (left_valid_nxt),
    .right_valid    (right_valid_nxt),
    .left_cand      (left_nxt),
    .right_cand     (right_nxt),
    .cut_time       (cut_time_r),
    .clip_threshold (clip_threshold_r),
    .found          (res_found),
    .left_sel       (res_left),
    .right_sel      (res_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_acc_r    <= '0;
      frame_cnt_r   <= '0;
      search_done_r <= 1'b0;
      left_valid_r  <= 1'b0;
      right_valid_r <= 1'b0;
      left_r        <= '0;
      right_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        if (in_last) begin
          time_acc_r    <= '0;
          frame_cnt_r   <= '0;
          search_done_r <= 1'b0;
          left_valid_r  <= 1'b0;
          right_valid_r <= 1'b0;
          left_r        <= '0;
          right_r       <= '0;
        end else begin
          time_acc_r    <= time_acc_nxt;
          frame_cnt_r   <= frame_cnt_nxt;
          search_done_r <= search_done_nxt;
          left_valid_r  <= left_valid_nxt;
          right_valid_r <= right_valid_nxt;
          left_r        <= left_nxt;
          right_r       <= right_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      out_found_r <= res_found;
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_left_index   = out_left_r.index;
  assign out_left_pos     = out_left_r.pos;
  assign out_left_offset  = out_left_r.offset;
  assign out_right_index  = out_right_r.index;
  assign out_right_pos    = out_right_r.pos;
  assign out_right_offset = out_right_r.offset;

endmodule

`default_nettype wire

// ----- src/kcpf_checker.sv -----
// Port-level checks on the cut point finder, bound to its top level.
`default_nettype none
`include "keyframe_cut_point_finder_core_defines.svh"

module kcpf_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         in_last,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_found,
  input wire logic [kcpf_pkg::IDX_W-1:0]   out_left_index,
  input wire logic [kcpf_pkg::POS_W-1:0]   out_left_pos,
  input wire logic [kcpf_pkg::TIME_W-1:0]  out_left_offset,
  input wire logic [kcpf_pkg::IDX_W-1:0]   out_right_index,
  input wire logic [kcpf_pkg::TIME_W-1:0]  out_right_offset
);

  // A stalled result word stays valid and keeps its right offset and left index.
  `KCPF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_right_offset) && $stable(out_left_index), "result word changed while stalled")
  // The last word of a list yields a result in the next cycle.
  `KCPF_ASSERT_NEXT(a_last_result, in_valid && !in_stall && in_last, out_valid, "no result after the last word")
  // The input side is held back only by a waiting result.
  `KCPF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a waiting result")
  // An empty result carries zeros, and a found pair never has its left end after its right.
  `KCPF_ASSERT_NOW(a_empty_zero, out_valid && !out_found, out_left_index == '0 && out_left_pos == '0 && out_right_index == '0 && out_right_offset == '0, "empty result not zero")
  `KCPF_ASSERT_NOW(a_pair_order, out_valid && out_found, out_left_offset <= out_right_offset, "left keyframe lies after right keyframe")

endmodule

bind keyframe_cut_point_finder_core kcpf_checker u_kcpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_left_index   (out_left_index),
  .out_left_pos     (out_left_pos),
  .out_left_offset  (out_left_offset),
  .out_right_index  (out_right_index),
  .out_right_offset (out_right_offset)
);

`default_nettype wire

// ----- dv/keyframe_cut_point_finder_core_tb.sv -----
// Self-checking testbench for the keyframe cut point finder core.
module keyframe_cut_point_finder_core_tb;
  import kcpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int FRAME_IDX_MAX  = (MAX_FRAMES - 1 > 65535) ? 65535 : MAX_FRAMES - 1;
  localparam logic [THR_W-1:0] CLIP_DEFAULT = 24'd6000;

  typedef struct packed {
    logic              video;
    logic              key;
    logic              clk_ref;
    logic [DUR_W-1:0]  dur;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_t;

  typedef struct packed {
    logic       found;
    kcpf_cand_t left;
    kcpf_cand_t right;
  } cut_word_t;

  typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_is_video_frame = 1'b0;
  logic                 in_is_keyframe = 1'b0;
  logic                 in_has_clock_ref = 1'b0;
  logic [DUR_W-1:0]     in_duration = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [IDX_W-1:0]     out_left_index;
  logic [POS_W-1:0]     out_left_pos;
  logic [TIME_W-1:0]    out_left_offset;
  logic [IDX_W-1:0]     out_right_index;
  logic [POS_W-1:0]     out_right_pos;
  logic [TIME_W-1:0]    out_right_offset;

  keyframe_cut_point_finder_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_is_video_frame (in_is_video_frame),
    .in_is_keyframe    (in_is_keyframe),
    .in_has_clock_ref  (in_has_clock_ref),
    .in_duration       (in_duration),
    .in_position       (in_position),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_left_index    (out_left_index),
    .out_left_pos      (out_left_pos),
    .out_left_offset   (out_left_offset),
    .out_right_index   (out_right_index),
    .out_right_pos     (out_right_pos),
    .out_right_offset  (out_right_offset)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Register copies and scan state of the predictor.
  logic [TIME_W-1:0] cut_cfg = '0;
  logic              video_only_cfg = 1'b0;
  logic [THR_W-1:0]  clip_cfg = CLIP_DEFAULT;
  logic [TIME_W-1:0] time_sum = '0;
  logic [IDX_W-1:0]  frame_idx = '0;
  logic              scan_done = 1'b0;
  logic              have_left = 1'b0;
  logic              have_right = 1'b0;
  kcpf_cand_t        left_cand = '0;
  kcpf_cand_t        right_cand = '0;

  cut_word_t pending_cuts[$];
  int        faults = 0;
  int        quiet_cycles = 0;

  // Sender and receiver idling controls.
  int       gap_max = 0;
  int       burst_left = 1;
  rx_mode_t rx_mode = RX_READY;
  int       rx_phase = 0;
  int       hold_ticket = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  function automatic frame_t descriptor(input logic video, key, clk_ref,
                                        input logic [DUR_W-1:0] dur,
                                        input logic [POS_W-1:0] pos, input logic last);
    frame_t f;
    f.video = video; f.key = key; f.clk_ref = clk_ref;
    f.dur = dur; f.pos = pos; f.last = last;
    return f;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [DUR_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - DUR_W){1'b0}}, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  // Applies one accepted descriptor to the scan state; a closing word queues its result.
  task automatic advance_scan(input frame_t f);
    logic [IDX_W-1:0] idx;
    kcpf_cand_t       lc, rc;
    cut_word_t        w;
    idx = frame_idx;
    if (int'(frame_idx) < FRAME_IDX_MAX) frame_idx = frame_idx + 1'b1;
    if (!scan_done && !(video_only_cfg && !f.video)) begin
      if (!f.key || !f.clk_ref) begin
        time_sum = sat_add(time_sum, f.dur);
      end else if (time_sum >= cut_cfg) begin
        have_right = 1'b1;
        right_cand = '{index: idx, pos: f.pos, offset: time_sum};
        scan_done = 1'b1;
      end else begin
        have_left = 1'b1;
        left_cand = '{index: idx, pos: f.pos, offset: time_sum};
        if (cut_cfg - time_sum < TIME_W'(clip_cfg)) scan_done = 1'b1;
        else time_sum = sat_add(time_sum, f.dur);
      end
    end
    if (f.last) begin
      w = '0;
      if (have_left || have_right) begin
        lc = left_cand;
        rc = right_cand;
        if (!have_right) rc = lc;
        // With no left keyframe, or a right one before the cut or close past it, the right stands for both sides.
        if (!have_left || rc.offset < cut_cfg ||
            rc.offset - cut_cfg < TIME_W'(clip_cfg)) lc = rc;
        w.found = 1'b1;
        w.left = lc;
        w.right = rc;
      end
      pending_cuts.push_back(w);
      time_sum = '0;
      frame_idx = '0;
      scan_done = 1'b0;
      have_left = 1'b0;
      have_right = 1'b0;
      left_cand = '0;
      right_cand = '0;
    end
  endtask

  task automatic report_fault(input string what);
    if (faults < 10) $display("mismatch at %0t: %s", $time, what);
    faults++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) report_fault($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  task automatic check_cut_word();
    cut_word_t want;
    if (pending_cuts.size() == 0) begin
      report_fault($sformatf("unexpected result word, found %0b left %0h right %0h",
                             out_found, out_left_index, out_right_index));
    end else begin
      want = pending_cuts.pop_front();
      check_field("found", 32'(want.found), 32'(out_found));
      check_field("left_index", 32'(want.left.index), 32'(out_left_index));
      check_field("left_pos", 32'(want.left.pos), 32'(out_left_pos));
      check_field("left_offset", 32'(want.left.offset), 32'(out_left_offset));
      check_field("right_index", 32'(want.right.index), 32'(out_right_index));
      check_field("right_pos", 32'(want.right.pos), 32'(out_right_pos));
      check_field("right_offset", 32'(want.right.offset), 32'(out_right_offset));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        advance_scan(descriptor(in_is_video_frame, in_is_keyframe, in_has_clock_ref,
                                in_duration, in_position, in_last));
      if (out_valid && !out_stall) check_cut_word();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("keyframe_cut_point_finder_core_tb: done, errors");
        $finish;
      end
    end
  end

  // Receiver: a long hold-off when one is requested, otherwise the current stall mode.
  always @(negedge clk) begin
    rx_phase++;
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall = ($urandom_range(0, 99) < 35);
        RX_PATTERN: out_stall = ((rx_phase % 9) < 4);
        default:    out_stall = 1'b0;
      endcase
    end
  end

  task automatic write_reg(input kcpf_reg_t r, input logic [TIME_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_CUT_TIME:       cut_cfg = d;
      REG_VIDEO_ONLY:     video_only_cfg = d[0];
      REG_CLIP_THRESHOLD: clip_cfg = d[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offers one word, waits for the falling edge after it is taken, then may idle a random gap.
  task automatic send_frame(input frame_t f);
    int gap;
    in_valid = 1'b1;
    in_is_video_frame = f.video;
    in_is_keyframe = f.key;
    in_has_clock_ref = f.clk_ref;
    in_duration = f.dur;
    in_position = f.pos;
    in_last = f.last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Lets the block drain before a register write or the end of the run.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_cuts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly plausible frame lists with random content; one list in eight is pure noise.
  task automatic send_random_lists(input int budget, len_lo, len_hi, dur_lo, dur_hi);
    int     sent, len, kind;
    frame_t f;
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(len_lo, len_hi);
      kind = $urandom_range(0, 7);
      for (int i = 0; i < len; i++) begin
        if (kind == 0) begin
          f.video = 1'($urandom_range(0, 1));
          f.key = 1'($urandom_range(0, 1));
          f.clk_ref = 1'($urandom_range(0, 1));
          f.dur = DUR_W'($urandom);
        end else begin
          f.video = ($urandom_range(0, 9) != 0);
          f.key = ($urandom_range(0, 5) == 0);
          f.clk_ref = ($urandom_range(0, 4) != 0);
          f.dur = ($urandom_range(0, 31) == 0) ? DUR_W'($urandom) :
                                                 DUR_W'($urandom_range(dur_lo, dur_hi));
        end
        f.pos = POS_W'($urandom);
        f.last = (i == len - 1);
        send_frame(f);
        sent++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    gap_max = 0;
    rx_mode = RX_READY;
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd5, 31'd77, 1'b1));
    settle();
  endtask

  task automatic test_special_cases();
    write_reg(REG_CUT_TIME, 31'd20000);
    write_reg(REG_VIDEO_ONLY, 31'd1);
    write_reg(REG_CLIP_THRESHOLD, 31'(CLIP_DEFAULT));
    gap_max = 3;
    rx_mode = RX_RANDOM;
    // Nothing found: the only keyframe is outside the video stream.
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'hFF_FFFF, 31'd0, 1'b0));
    send_frame(descriptor(1'b0, 1'b1, 1'b1, 24'd100, 31'h7FFF_FFFF, 1'b1));
    // Left keyframe only; a keyframe without clock reference just adds time.
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd3000, 31'd1000, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b0, 24'd3000, 31'd2000, 1'b0));
    send_frame(descriptor(1'b1, 1'b0, 1'b1, 24'd0, 31'd3000, 1'b1));
    // Right keyframe only, close to the cut, then words after the search has ended.
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'd20000, 31'd10, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd500, 31'd20, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd0, 31'd30, 1'b0));
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'hFF_FFFF, 31'd40, 1'b1));
    // Left and a right keyframe well past the cut.
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd3000, 31'd100, 1'b0));
    send_frame(descriptor(1'b1, 1'b0, 1'b1, 24'd30000, 31'd200, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd0, 31'd300, 1'b0));
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'd0, 31'd400, 1'b1));
    // Left keyframe within the threshold ends the search.
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'd16000, 31'd500, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd1, 31'd600, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd0, 31'd700, 1'b1));
    // Left keyframe, then a near right keyframe that replaces it.
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd1000, 31'd800, 1'b0));
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'd21000, 31'd900, 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd0, 31'd1000, 1'b1));
    settle();
  endtask

  task automatic test_time_saturation();
    write_reg(REG_CUT_TIME, 31'h7FFF_FFFF);
    write_reg(REG_VIDEO_ONLY, {30'($urandom), 1'b0});
    write_reg(REG_CLIP_THRESHOLD, {7'($urandom), 24'hFF_FFFF});
    gap_max = 2;
    rx_mode = RX_PATTERN;
    // Enough long frames to pin the running offset at its ceiling.
    for (int i = 0; i < 136; i++)
      send_frame(descriptor(1'b1, 1'b0, 1'b1, DUR_W'($urandom_range(16000000, 16777215)),
                            POS_W'($urandom), 1'b0));
    send_frame(descriptor(1'b1, 1'b1, 1'b1, 24'd0, POS_W'($urandom), 1'b0));
    send_frame(descriptor(1'b1, 1'b0, 1'b0, 24'd0, POS_W'($urandom), 1'b1));
    send_random_lists(100, 100, 100, 14000000, 16777215);
    settle();
  endtask

  task automatic test_random_lists();
    write_reg(REG_CUT_TIME, 31'($urandom_range(50000, 150000)));
    write_reg(REG_VIDEO_ONLY, {30'($urandom), 1'b1});
    write_reg(REG_CLIP_THRESHOLD, 31'(CLIP_DEFAULT));
    gap_max = 6;
    rx_mode = RX_RANDOM;
    send_random_lists(150, 5, 50, 1000, 5000);
    settle();

    // Cut at the start of the list and no threshold, at full rate.
    write_reg(REG_CUT_TIME, 31'd0);
    write_reg(REG_VIDEO_ONLY, {30'($urandom), 1'b0});
    write_reg(REG_CLIP_THRESHOLD, {7'($urandom), 24'd0});
    gap_max = 0;
    rx_mode = RX_READY;
    send_random_lists(130, 1, 20, 0, 3000);
    settle();

    write_reg(REG_CUT_TIME, 31'($urandom_range(0, 20000)));
    write_reg(REG_VIDEO_ONLY, 31'($urandom));
    write_reg(REG_CLIP_THRESHOLD, 31'($urandom));
    gap_max = 3;
    rx_mode = RX_PATTERN;
    send_random_lists(130, 1, 12, 0, 2000);
    settle();

    write_reg(REG_CUT_TIME, 31'($urandom_range(10000, 40000)));
    write_reg(REG_VIDEO_ONLY, 31'd0);
    write_reg(REG_CLIP_THRESHOLD, 31'($urandom_range(0, 20000)));
    gap_max = 10;
    rx_mode = RX_RANDOM;
    send_random_lists(130, 3, 30, 500, 3000);
    settle();
  endtask

  // Short lists at full rate while the receiver holds off, so a result word backs up.
  task automatic test_backpressure();
    gap_max = 0;
    rx_mode = RX_RANDOM;
    hold_ticket++;
    send_random_lists(60, 1, 3, 0, 3000);
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_time_saturation();
    test_random_lists();
    test_backpressure();
    settle();
    repeat (4) @(posedge clk);
    faults += pending_cuts.size();
    if (faults == 0) begin
      $display("keyframe_cut_point_finder_core_tb: done, clean");
    end else begin
      $display("keyframe_cut_point_finder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
